@@ hw/rtl/bwbs_pkg.sv @@
package bwbs_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_DATA   = 2'd0,
      OP_WRITE_AMOUNT = 2'd1,
      OP_READ         = 2'd2,
      OP_UNUSED       = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_PLAIN         = 3'd0,
      MODE_REVERSED      = 3'd1,
      MODE_INVERTED      = 3'd2,
      MODE_INV_REVERSED  = 3'd3,
      MODE_NO_SHIFT      = 3'd4,
      MODE_NO_SHIFT_REV  = 3'd5,
      MODE_VARIANT       = 3'd6,
      MODE_SPARE         = 3'd7
   } read_mode_type;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WINDOW_W = 2 * BYTE_W;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned OP_W     = 2;

   // A shift amount at or above this shifts the whole window out, so the shifted byte is zero.
   localparam logic [BYTE_W-1:0] SHIFT_LIMIT = 8'h10;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] read_data;
   } result_type;

   function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[BYTE_W-1-i] = v[i];
      end
      return r;
   endfunction

   // Bits 15..8 of the word shifted left by the amount, zero once the amount reaches 16.
   function automatic logic [BYTE_W-1:0] window_byte(input logic [WINDOW_W-1:0] word,
                                                     input logic [BYTE_W-1:0]   amount);
      logic [WINDOW_W-1:0] shifted;
      shifted = word << amount[3:0];
      if (amount >= SHIFT_LIMIT) begin
         return '0;
      end
      return shifted[WINDOW_W-1:BYTE_W];
   endfunction

endpackage

@@ hw/rtl/byte_window_barrel_shifter.sv @@
// Channel   Direction  Payload
// req_      in         tuser = opcode [1:0], tdata = data [7:0]
// rsp_      out        tdata = read_data [7:0]
// csr_      in         csr_wdata = read_mode [2:0], written when csr_we is high
//
// One transfer per cycle is sustained on each channel while rsp_ is not stalled. An item
// passes through the input register, where writes update the window and reads form their byte;
// a read result is offered on rsp_ from the edge at which it leaves that register. A stalled
// rsp_ side is absorbed by a two-entry output stage, and req_tready drops only once both
// entries hold results.
// Reset is synchronous: it empties the pipeline and clears the window, count and mode.
module byte_window_barrel_shifter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bwbs_pkg::OP_W-1:0]           req_tuser,   // [1:0] opcode
   input  logic [bwbs_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] data
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bwbs_pkg::BYTE_W-1:0]         rsp_tdata,   // [7:0] read_data
   input  logic                                csr_we,
   input  logic [bwbs_pkg::MODE_W-1:0]         csr_wdata
);

   bwbs_pkg::result_type result;
   logic                 out_ready;

   bwbs_shift_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .out_ready  (out_ready),
      .result     (result)
   );

   bwbs_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_ready)
      else $error("Result pushed into a full output stage.");

   a_full_means_valid: assert property (@(posedge clock) disable iff (reset)
      !out_ready |-> rsp_tvalid)
      else $error("Skid entry holds a result while the output is empty.");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Result offered straight after reset.");
`endif

endmodule

@@ hw/rtl/bwbs_shift_core.sv @@
module bwbs_shift_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bwbs_pkg::OP_W-1:0]           req_tuser,
   input  logic [bwbs_pkg::BYTE_W-1:0]         req_tdata,
   input  logic                                csr_we,
   input  logic [bwbs_pkg::MODE_W-1:0]         csr_wdata,
   input  logic                                out_ready,
   output bwbs_pkg::result_type                result
);

   logic                              a_valid_ff;
   bwbs_pkg::opcode_type              a_op_ff;
   logic [bwbs_pkg::BYTE_W-1:0]       a_data_ff;

   bwbs_pkg::read_mode_type           mode_ff;
   logic [bwbs_pkg::BYTE_W-1:0]       high_ff;
   logic [bwbs_pkg::BYTE_W-1:0]       low_ff;
   logic [bwbs_pkg::BYTE_W-1:0]       count_ff;
   logic [bwbs_pkg::BYTE_W-1:0]       high_in;
   logic [bwbs_pkg::BYTE_W-1:0]       low_in;
   logic [bwbs_pkg::BYTE_W-1:0]       count_in;

   logic                              is_read;
   logic                              advance;
   logic                              req_take;
   logic [bwbs_pkg::BYTE_W-1:0]       plain;
   logic [bwbs_pkg::BYTE_W-1:0]       variant_high;
   logic [bwbs_pkg::BYTE_W-1:0]       read_value;

   assign is_read    = (a_op_ff == bwbs_pkg::OP_READ);
   // A read leaves the input register only when the output side has room for it.
   assign advance    = a_valid_ff && (!is_read || out_ready);
   assign req_tready = !a_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_take) begin
         a_valid_ff <= 1'b1;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_op_ff   <= bwbs_pkg::opcode_type'(req_tuser);
         a_data_ff <= req_tdata;
      end
   end

   always_comb begin
      high_in  = high_ff;
      low_in   = low_ff;
      count_in = count_ff;
      if (advance) begin
         case (a_op_ff)
            bwbs_pkg::OP_WRITE_DATA: begin
               low_in  = high_ff;
               high_in = a_data_ff;
            end
            bwbs_pkg::OP_WRITE_AMOUNT: begin
               count_in = a_data_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bwbs_pkg::MODE_PLAIN;
         high_ff  <= '0;
         low_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            mode_ff <= bwbs_pkg::read_mode_type'(csr_wdata);
         end
         high_ff  <= high_in;
         low_ff   <= low_in;
         count_ff <= count_in;
      end
   end

   assign plain = bwbs_pkg::window_byte({high_ff, low_ff}, count_ff);

   // For large counts the variant mode reverses the whole word and shifts by 255 minus the count.
   assign variant_high = bwbs_pkg::window_byte({bwbs_pkg::rev8(low_ff), bwbs_pkg::rev8(high_ff)},
                                               ~count_ff);

   always_comb begin
      unique case (mode_ff)
         bwbs_pkg::MODE_REVERSED:     read_value = bwbs_pkg::rev8(plain);
         bwbs_pkg::MODE_INVERTED:     read_value = ~plain;
         bwbs_pkg::MODE_INV_REVERSED: read_value = bwbs_pkg::rev8(~plain);
         bwbs_pkg::MODE_NO_SHIFT:     read_value = high_ff;
         bwbs_pkg::MODE_NO_SHIFT_REV: read_value = bwbs_pkg::rev8(high_ff);
         bwbs_pkg::MODE_VARIANT: begin
            if (count_ff < bwbs_pkg::SHIFT_LIMIT) begin
               read_value = plain;
            end else begin
               read_value = variant_high;
            end
         end
         default:                     read_value = plain;
      endcase
   end

   assign result.valid     = advance && is_read;
   assign result.read_data = read_value;

endmodule

@@ hw/rtl/bwbs_out_stage.sv @@
module bwbs_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  bwbs_pkg::result_type          result,
   output logic                          out_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bwbs_pkg::BYTE_W-1:0]   rsp_tdata
);

   logic                          main_valid_ff;
   logic [bwbs_pkg::BYTE_W-1:0]   main_data_ff;
   logic                          skid_valid_ff;
   logic [bwbs_pkg::BYTE_W-1:0]   skid_data_ff;
   logic                          main_free;

   // The skid entry catches a result that arrives while the main entry is stalled.
   assign out_ready = !skid_valid_ff;
   assign main_free = !main_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= result.valid;
         end
      end else if (result.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         if (skid_valid_ff) begin
            main_data_ff <= skid_data_ff;
         end else begin
            main_data_ff <= result.read_data;
         end
      end else if (result.valid) begin
         skid_data_ff <= result.read_data;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

endmodule

@@ verif/bwbs_read_checker.sv @@
`timescale 1ns / 100ps

module bwbs_read_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [bwbs_pkg::OP_W-1:0]   req_tuser,
   input  logic [bwbs_pkg::BYTE_W-1:0] req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [bwbs_pkg::BYTE_W-1:0] rsp_tdata,
   input  logic                        csr_we,
   input  logic [bwbs_pkg::MODE_W-1:0] csr_wdata,
   output int unsigned                 fail_count,
   output int unsigned                 pending_reads,
   output int unsigned                 results_checked
);

   bwbs_pkg::read_mode_type     read_mode;
   logic [bwbs_pkg::BYTE_W-1:0] window_high;
   logic [bwbs_pkg::BYTE_W-1:0] window_low;
   logic [bwbs_pkg::BYTE_W-1:0] window_count;
   logic [bwbs_pkg::BYTE_W-1:0] expected_bytes[$];
   int unsigned                 mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [bwbs_pkg::BYTE_W-1:0] mirror_byte(
         input logic [bwbs_pkg::BYTE_W-1:0] b);
      logic [bwbs_pkg::BYTE_W-1:0] m;
      for (int i = 0; i < bwbs_pkg::BYTE_W; i++) begin
         m[i] = b[bwbs_pkg::BYTE_W-1-i];
      end
      return m;
   endfunction

   // Top byte of the window after a left shift; everything has fallen out by 16.
   function automatic logic [bwbs_pkg::BYTE_W-1:0] shifted_window(
         input logic [bwbs_pkg::WINDOW_W-1:0] word,
         input logic [bwbs_pkg::BYTE_W-1:0]   amount);
      logic [bwbs_pkg::WINDOW_W-1:0] moved;
      if (amount >= bwbs_pkg::SHIFT_LIMIT) begin
         return '0;
      end
      moved = word << amount;
      return moved[bwbs_pkg::WINDOW_W-1:bwbs_pkg::BYTE_W];
   endfunction

   function automatic logic [bwbs_pkg::BYTE_W-1:0] predict_read_byte(
         input bwbs_pkg::read_mode_type     mode,
         input logic [bwbs_pkg::BYTE_W-1:0] hi,
         input logic [bwbs_pkg::BYTE_W-1:0] lo,
         input logic [bwbs_pkg::BYTE_W-1:0] count);
      logic [bwbs_pkg::BYTE_W-1:0] plain;
      plain = shifted_window({hi, lo}, count);
      case (mode)
         bwbs_pkg::MODE_REVERSED:     return mirror_byte(plain);
         bwbs_pkg::MODE_INVERTED:     return ~plain;
         bwbs_pkg::MODE_INV_REVERSED: return mirror_byte(~plain);
         bwbs_pkg::MODE_NO_SHIFT:     return hi;
         bwbs_pkg::MODE_NO_SHIFT_REV: return mirror_byte(hi);
         bwbs_pkg::MODE_VARIANT: begin
            if (count < bwbs_pkg::SHIFT_LIMIT) begin
               return plain;
            end
            // High counts mirror the whole word and shift by the complement of the count.
            return shifted_window({mirror_byte(lo), mirror_byte(hi)}, ~count);
         end
         default:                     return plain;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch_channels
      logic [bwbs_pkg::BYTE_W-1:0] wanted;
      if (reset) begin
         read_mode    = bwbs_pkg::MODE_PLAIN;
         window_high  = '0;
         window_low   = '0;
         window_count = '0;
         expected_bytes.delete();
         pending_reads   <= 0;
         results_checked <= 0;
      end else begin
         // The result side is checked first so that a stray result cannot consume a read
         // that is only being accepted at this very edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("read_data 0x%02h with no read waiting", rsp_tdata));
            end else begin
               wanted = expected_bytes.pop_front();
               if (rsp_tdata !== wanted) begin
                  report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h (mode %0d)",
                                            rsp_tdata, wanted, read_mode));
               end
               results_checked <= results_checked + 1;
            end
         end
         if (csr_we) begin
            read_mode = bwbs_pkg::read_mode_type'(csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            case (bwbs_pkg::opcode_type'(req_tuser))
               bwbs_pkg::OP_WRITE_DATA: begin
                  window_low  = window_high;
                  window_high = req_tdata;
               end
               bwbs_pkg::OP_WRITE_AMOUNT: begin
                  window_count = req_tdata;
               end
               bwbs_pkg::OP_READ: begin
                  expected_bytes.push_back(predict_read_byte(read_mode, window_high,
                                                             window_low, window_count));
               end
               default: ;
            endcase
         end
         pending_reads <= expected_bytes.size();
      end
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned RANDOM_ITEMS  = 1800;
   localparam int unsigned PHASES        = 16;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 60;
   localparam int unsigned STALL_LIMIT   = 2000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [bwbs_pkg::OP_W-1:0]   req_tuser;
   logic [bwbs_pkg::BYTE_W-1:0] req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [bwbs_pkg::BYTE_W-1:0] rsp_tdata;
   logic                        csr_we;
   logic [bwbs_pkg::MODE_W-1:0] csr_wdata;

   int unsigned mismatches;
   int unsigned pending_reads;
   int unsigned results_checked;
   int unsigned items_sent  = 0;
   int unsigned idle_cycles = 0;
   bit          no_idle      = 1'b0;
   bit          hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_window_barrel_shifter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   bwbs_read_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (mismatches),
      .pending_reads   (pending_reads),
      .results_checked (results_checked)
   );

   // Offers one transfer after a random gap and returns at the edge that accepts it.
   task automatic send_item(input bwbs_pkg::opcode_type op,
                            input logic [bwbs_pkg::BYTE_W-1:0] value);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // The mode register may only change once every read has come back and the
   // pipeline has had time to retire any trailing writes.
   task automatic set_read_mode(input bwbs_pkg::read_mode_type mode);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Counts are biased towards the interesting regions: in range, the zero band and the
   // top band where the variant mode reads something again.
   function automatic logic [bwbs_pkg::BYTE_W-1:0] pick_count();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 8'($urandom_range(0, 15));
         4:          return 8'($urandom_range(16, 239));
         5:          return 8'($urandom_range(240, 255));
         6: begin
            case ($urandom_range(0, 3))
               0:       return 8'd15;
               1:       return 8'd16;
               2:       return 8'd239;
               default: return 8'd240;
            endcase
         end
         default:    return 8'($urandom);
      endcase
   endfunction

   // Mostly fill-then-read sequences with random content; the rest is noise.
   task automatic send_random_group();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         send_item(bwbs_pkg::opcode_type'($urandom_range(0, 3)), 8'($urandom));
      end else if (kind == 1) begin
         send_item(bwbs_pkg::OP_UNUSED, 8'($urandom));
      end else begin
         repeat ($urandom_range(0, 2)) send_item(bwbs_pkg::OP_WRITE_DATA, 8'($urandom));
         if (kind > 4) begin
            send_item(bwbs_pkg::OP_WRITE_AMOUNT, pick_count());
         end
         repeat ($urandom_range(1, 3)) send_item(bwbs_pkg::OP_READ, 8'($urandom));
      end
   endtask

   initial begin
      int unsigned stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (hold_request) begin
            stall += HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("No transfer on either channel for %0d cycles, %0d reads outstanding.",
               STALL_LIMIT, pending_reads);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      bwbs_pkg::read_mode_type mode;
      int unsigned             target;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= bwbs_pkg::OP_WRITE_DATA;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= bwbs_pkg::MODE_PLAIN;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Window and count are clear straight after reset.
      send_item(bwbs_pkg::OP_READ, 8'hFF);
      send_item(bwbs_pkg::OP_WRITE_DATA, 8'hFF);
      send_item(bwbs_pkg::OP_WRITE_DATA, 8'h00);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd4);
      send_item(bwbs_pkg::OP_READ, 8'h00);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd15);
      send_item(bwbs_pkg::OP_READ, 8'h00);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd16);
      send_item(bwbs_pkg::OP_READ, 8'h00);
      // An unused opcode must leave the count and the window alone.
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd0);
      send_item(bwbs_pkg::OP_UNUSED, 8'hFF);
      send_item(bwbs_pkg::OP_READ, 8'h5A);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'hFF);
      send_item(bwbs_pkg::OP_READ, 8'h00);

      // Variant mode across the zero band, its upper edge and the top count.
      set_read_mode(bwbs_pkg::MODE_VARIANT);
      send_item(bwbs_pkg::OP_WRITE_DATA, 8'h01);
      send_item(bwbs_pkg::OP_WRITE_DATA, 8'hC3);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd239);
      send_item(bwbs_pkg::OP_READ, 8'h00);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd240);
      send_item(bwbs_pkg::OP_READ, 8'h00);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd255);
      send_item(bwbs_pkg::OP_READ, 8'h00);
      send_item(bwbs_pkg::OP_WRITE_AMOUNT, 8'd7);
      send_item(bwbs_pkg::OP_READ, 8'h00);

      for (int phase = 0; phase < PHASES; phase++) begin
         mode = (phase < 8) ? bwbs_pkg::read_mode_type'(phase)
                            : bwbs_pkg::read_mode_type'($urandom_range(0, 7));
         set_read_mode(mode);
         no_idle = (phase % 5 == 4);
         if (phase == 2) begin
            // Back-to-back reads against a long receiver hold-off fill the output stage
            // until the input side has to stall.
            no_idle      = 1'b1;
            hold_request = 1'b1;
            repeat (24) send_item(bwbs_pkg::OP_READ, 8'($urandom));
            no_idle      = 1'b0;
         end
         target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target) send_random_group();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d request transfers and %0d checked reads over all eight read modes,",
               items_sent, results_checked);
      $display("with random idling on both sides and one %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (mismatches == 0 && pending_reads == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
